// ===== hdl/vat_pkg.sv =====
// Shared types, register map, mode and axis codes for the vertex affine transform.
// Holds the whole-degree sine table used by the angle unit. No dependencies.
`default_nettype none

package vat_pkg;

    localparam int COORD_WIDTH_DEFAULT = 16;
    localparam int APB_ADDR_W          = 5;
    localparam int APB_DATA_W          = 32;
    localparam int PARAM_W             = 11;
    localparam int ANGLE_W             = 13;
    localparam int TRIG_W              = 17;

    localparam logic [1:0] MODE_TRANSLATE = 2'd0;
    localparam logic [1:0] MODE_SCALE     = 2'd1;
    localparam logic [1:0] MODE_ROTATE    = 2'd2;
    localparam logic [1:0] MODE_NONE      = 2'd3;

    localparam logic [1:0] AXIS_X        = 2'd0;
    localparam logic [1:0] AXIS_Y        = 2'd1;
    localparam logic [1:0] AXIS_Z        = 2'd2;
    localparam logic [1:0] AXIS_IDENTITY = 2'd3;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_AXIS    = 3'd1;
    localparam logic [2:0] REG_PARAM_X = 3'd2;
    localparam logic [2:0] REG_PARAM_Y = 3'd3;
    localparam logic [2:0] REG_PARAM_Z = 3'd4;
    localparam logic [2:0] REG_ANGLE   = 3'd5;

    localparam logic signed [TRIG_W-1:0] Q15_ONE = 17'sd32768;

    localparam logic [15:0] SINE_DEG [0:90] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
        16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32768
    };

    function automatic logic [15:0] sine_deg(input logic [6:0] d);
        logic [15:0] v;
        if (d > 7'd90) begin
            v = 16'd32768;
        end else begin
            v = SINE_DEG[d];
        end
        return v;
    endfunction

    typedef struct packed {
        logic                      busy;
        logic signed [TRIG_W-1:0]  sin_v;
        logic signed [TRIG_W-1:0]  cos_v;
    } trig_t;

    typedef struct packed {
        logic [1:0]                mode;
        logic [1:0]                axis;
        logic signed [PARAM_W-1:0] param_x;
        logic signed [PARAM_W-1:0] param_y;
        logic signed [PARAM_W-1:0] param_z;
        logic signed [TRIG_W-1:0]  sin_v;
        logic signed [TRIG_W-1:0]  cos_v;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/vertex_affine_transform_core.sv =====
// Vertex affine transform core: register-bank port, angle unit and two-register stream path.
// Vertex and then result word are registered; one vertex per cycle sustained while m_tready
// is high. After a rotation_angle write, s_tready stays low while the angle unit settles.
// Reset (aresetn low, synchronous) empties both registers and loads mode and axis with 3.
// Depends on vat_pkg, vat_trig and vat_xform.
`default_nettype none

module vertex_affine_transform_core import vat_pkg::*; #(
    parameter  int COORD_WIDTH = COORD_WIDTH_DEFAULT,
    localparam int DATA_W      = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [DATA_W-1:0]     s_tdata,   // vx, vy, vz from bit 0 up, zero padded
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [DATA_W-1:0]          m_tdata,   // ox, oy, oz from bit 0 up, zero padded
    output logic [0:0]                 m_tuser,   // saturated
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int W = COORD_WIDTH;

    logic [1:0]                mode_reg, axis_reg;
    logic signed [PARAM_W-1:0] param_x_reg, param_y_reg, param_z_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic                      in_vld_reg, out_vld_reg;
    logic                      in_vld_next, out_vld_next;
    logic signed [W-1:0]       vx_reg, vy_reg, vz_reg;
    logic signed [W-1:0]       ox_reg, oy_reg, oz_reg;
    logic                      sat_reg;

    logic [2:0]          reg_idx;
    logic                cfg_wr, angle_wr;
    logic                in_take, in_move, out_adv;
    trig_t               trig;
    cfg_t                cfg;
    logic signed [W-1:0] ox_c, oy_c, oz_c;
    logic                sat_c;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[4:2];
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign angle_wr = cfg_wr && (reg_idx == REG_ANGLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_NONE;
            axis_reg    <= AXIS_IDENTITY;
            param_x_reg <= '0;
            param_y_reg <= '0;
            param_z_reg <= '0;
            angle_reg   <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MODE:    mode_reg    <= pwdata[1:0];
                REG_AXIS:    axis_reg    <= pwdata[1:0];
                REG_PARAM_X: param_x_reg <= pwdata[PARAM_W-1:0];
                REG_PARAM_Y: param_y_reg <= pwdata[PARAM_W-1:0];
                REG_PARAM_Z: param_z_reg <= pwdata[PARAM_W-1:0];
                REG_ANGLE:   angle_reg   <= pwdata[ANGLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE:    prdata = APB_DATA_W'(mode_reg);
            REG_AXIS:    prdata = APB_DATA_W'(axis_reg);
            REG_PARAM_X: prdata = APB_DATA_W'(param_x_reg);
            REG_PARAM_Y: prdata = APB_DATA_W'(param_y_reg);
            REG_PARAM_Z: prdata = APB_DATA_W'(param_z_reg);
            REG_ANGLE:   prdata = APB_DATA_W'(angle_reg);
            default:     prdata = '0;
        endcase
    end

    vat_trig u_trig (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (angle_wr),
        .angle   (pwdata[ANGLE_W-1:0]),
        .trig    (trig)
    );

    assign cfg.mode    = mode_reg;
    assign cfg.axis    = axis_reg;
    assign cfg.param_x = param_x_reg;
    assign cfg.param_y = param_y_reg;
    assign cfg.param_z = param_z_reg;
    assign cfg.sin_v   = trig.sin_v;
    assign cfg.cos_v   = trig.cos_v;

    vat_xform #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_xform (
        .vx        (vx_reg),
        .vy        (vy_reg),
        .vz        (vz_reg),
        .cfg       (cfg),
        .ox        (ox_c),
        .oy        (oy_c),
        .oz        (oz_c),
        .saturated (sat_c)
    );

    assign out_adv  = !out_vld_reg || m_tready;
    assign s_tready = !trig.busy && (!in_vld_reg || out_adv);
    assign in_take  = s_tvalid && s_tready;
    assign in_move  = in_vld_reg && out_adv;

    always_comb begin
        in_vld_next  = in_vld_reg;
        out_vld_next = out_vld_reg;
        if (in_take) begin
            in_vld_next = 1'b1;
        end else if (in_move) begin
            in_vld_next = 1'b0;
        end
        if (in_move) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            vx_reg <= s_tdata[W-1:0];
            vy_reg <= s_tdata[2*W-1:W];
            vz_reg <= s_tdata[3*W-1:2*W];
        end
        if (in_move) begin
            ox_reg  <= ox_c;
            oy_reg  <= oy_c;
            oz_reg  <= oz_c;
            sat_reg <= sat_c;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = DATA_W'({oz_reg, oy_reg, ox_reg});
    assign m_tuser  = sat_reg;

    a_angle_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        angle_wr |=> trig.busy)
        else $error("angle unit not busy after an angle write");

    a_trig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (trig.sin_v <= Q15_ONE) && (trig.sin_v >= -Q15_ONE) &&
        (trig.cos_v <= Q15_ONE) && (trig.cos_v >= -Q15_ONE))
        else $error("sine or cosine outside unit range");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_adv |=> m_tvalid)
        else $error("held vertex lost on its way to the result register");

endmodule

`default_nettype wire

// ===== hdl/vat_trig.sv =====
// Angle unit: reduces the rotation angle and builds Q1.15 sine and cosine
// by interpolating the whole-degree table over four pipeline stages. Uses vat_pkg.
`default_nettype none

module vat_trig import vat_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic signed [ANGLE_W-1:0] angle,
    output trig_t                          trig
);

    logic        v0_reg, v1_reg, v2_reg;
    logic [1:0]  q1_reg, q2_reg, q3_reg;
    logic [9:0]  rem_reg;
    logic [6:0]  d_reg    [2];
    logic [3:0]  f_reg    [2];
    logic [15:0] lo_reg   [2];
    logic [12:0] prod_reg [2];
    logic signed [TRIG_W-1:0] sin_reg, cos_reg;

    logic [13:0] a_full;
    logic [11:0] a_red;
    logic [1:0]  q_next;
    logic [9:0]  rem_next;
    logic [9:0]  r_lane    [2];
    logic [17:0] dp_lane   [2];
    logic [6:0]  d_next    [2];
    logic [3:0]  f_next    [2];
    logic [15:0] lo_next   [2];
    logic [15:0] hi_lane   [2];
    logic [9:0]  diff_lane [2];
    logic [12:0] prod_next [2];
    logic [26:0] m_lane    [2];
    logic signed [TRIG_W-1:0] s_lane [2];
    logic signed [TRIG_W-1:0] sin_next, cos_next;

    // reduce to 0..3599, then split into quadrant and remainder
    always_comb begin
        a_full = 14'(17'(angle) + 17'sd7200);
        if (a_full >= 14'd10800) begin
            a_red = 12'(a_full - 14'd10800);
        end else if (a_full >= 14'd7200) begin
            a_red = 12'(a_full - 14'd7200);
        end else if (a_full >= 14'd3600) begin
            a_red = 12'(a_full - 14'd3600);
        end else begin
            a_red = 12'(a_full);
        end
        if (a_red >= 12'd2700) begin
            q_next   = 2'd3;
            rem_next = 10'(a_red - 12'd2700);
        end else if (a_red >= 12'd1800) begin
            q_next   = 2'd2;
            rem_next = 10'(a_red - 12'd1800);
        end else if (a_red >= 12'd900) begin
            q_next   = 2'd1;
            rem_next = 10'(a_red - 12'd900);
        end else begin
            q_next   = 2'd0;
            rem_next = 10'(a_red);
        end
    end

    // lane 0 gives sine of the remainder, lane 1 of its complement
    always_comb begin
        r_lane[0] = rem_reg;
        r_lane[1] = 10'd900 - rem_reg;
        for (int i = 0; i < 2; i++) begin
            dp_lane[i]   = 18'(r_lane[i]) * 18'd205;
            d_next[i]    = dp_lane[i][17:11];
            f_next[i]    = 4'(r_lane[i] - 10'(d_next[i]) * 10'd10);
            lo_next[i]   = sine_deg(d_reg[i]);
            hi_lane[i]   = sine_deg(7'(d_reg[i] + 7'd1));
            diff_lane[i] = 10'(hi_lane[i] - lo_next[i]);
            prod_next[i] = 13'(diff_lane[i]) * 13'(f_reg[i]);
            m_lane[i]    = (27'(prod_reg[i]) + 27'd5) * 27'd6554;
            s_lane[i]    = TRIG_W'(lo_reg[i]) + TRIG_W'(m_lane[i][25:16]);
        end
    end

    always_comb begin
        case (q3_reg)
            2'd0: begin
                sin_next = s_lane[0];
                cos_next = s_lane[1];
            end
            2'd1: begin
                sin_next = s_lane[1];
                cos_next = -s_lane[0];
            end
            2'd2: begin
                sin_next = -s_lane[0];
                cos_next = -s_lane[1];
            end
            default: begin
                sin_next = -s_lane[1];
                cos_next = s_lane[0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            sin_reg <= '0;
            cos_reg <= Q15_ONE;
        end else begin
            v0_reg <= start;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            if (v2_reg) begin
                sin_reg <= sin_next;
                cos_reg <= cos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q1_reg  <= q_next;
        rem_reg <= rem_next;
        q2_reg  <= q1_reg;
        q3_reg  <= q2_reg;
        for (int i = 0; i < 2; i++) begin
            d_reg[i]    <= d_next[i];
            f_reg[i]    <= f_next[i];
            lo_reg[i]   <= lo_next[i];
            prod_reg[i] <= prod_next[i];
        end
    end

    assign trig.busy  = v0_reg | v1_reg | v2_reg;
    assign trig.sin_v = sin_reg;
    assign trig.cos_v = cos_reg;

endmodule

`default_nettype wire

// ===== hdl/vat_xform.sv =====
// Transform datapath: translate, scale or axis rotation of one vertex (mode 3 gives zero) with
// rounding and saturation to the coordinate range. Uses vat_pkg.
`default_nettype none

module vat_xform import vat_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
    input  wire logic signed [COORD_WIDTH-1:0] vx,
    input  wire logic signed [COORD_WIDTH-1:0] vy,
    input  wire logic signed [COORD_WIDTH-1:0] vz,
    input  cfg_t                               cfg,
    output logic signed [COORD_WIDTH-1:0]      ox,
    output logic signed [COORD_WIDTH-1:0]      oy,
    output logic signed [COORD_WIDTH-1:0]      oz,
    output logic                               saturated
);

    localparam int W  = COORD_WIDTH;
    localparam int PW = W + TRIG_W;
    localparam int SW = PW + 1;
    localparam int RW = W + 19;
    localparam int XW = W + PARAM_W;
    localparam logic signed [RW-1:0] CMAX = RW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] CMIN = -CMAX - RW'(1);

    logic signed [W-1:0]       a_v, b_v;
    logic signed [PW-1:0]      ac, as_p, bc, bs;
    logic signed [SW-1:0]      p_sum, q_sum, p_rnd, q_rnd;
    logic signed [W+2:0]       p_q15, q_q15;
    logic signed [XW-1:0]      sx, sy, sz;
    logic signed [RW-1:0]      rx, ry, rz;
    logic [W:0]                cx, cy, cz;

    function automatic logic [W:0] clip(input logic signed [RW-1:0] v);
        logic [W:0] res;
        if (v > CMAX) begin
            res = {1'b1, CMAX[W-1:0]};
        end else if (v < CMIN) begin
            res = {1'b1, CMIN[W-1:0]};
        end else begin
            res = {1'b0, v[W-1:0]};
        end
        return res;
    endfunction

    // pair (a, b) rotates to (a*c + b*s, b*c - a*s)
    always_comb begin
        case (cfg.axis)
            AXIS_X: begin
                a_v = vy;
                b_v = vz;
            end
            AXIS_Y: begin
                a_v = vz;
                b_v = vx;
            end
            default: begin
                a_v = vx;
                b_v = vy;
            end
        endcase
    end

    assign ac    = PW'(a_v) * PW'(cfg.cos_v);
    assign as_p  = PW'(a_v) * PW'(cfg.sin_v);
    assign bc    = PW'(b_v) * PW'(cfg.cos_v);
    assign bs    = PW'(b_v) * PW'(cfg.sin_v);
    assign p_sum = SW'(ac) + SW'(bs);
    assign q_sum = SW'(bc) - SW'(as_p);
    assign p_rnd = p_sum + SW'(16384);
    assign q_rnd = q_sum + SW'(16384);
    assign p_q15 = p_rnd[SW-1:15];
    assign q_q15 = q_rnd[SW-1:15];

    assign sx = XW'(vx) * XW'(cfg.param_x);
    assign sy = XW'(vy) * XW'(cfg.param_y);
    assign sz = XW'(vz) * XW'(cfg.param_z);

    always_comb begin
        case (cfg.mode)
            MODE_TRANSLATE: begin
                rx = RW'(vx) + (RW'(cfg.param_x) <<< 4);
                ry = RW'(vy) + (RW'(cfg.param_y) <<< 4);
                rz = RW'(vz) + (RW'(cfg.param_z) <<< 4);
            end
            MODE_SCALE: begin
                rx = RW'(sx);
                ry = RW'(sy);
                rz = RW'(sz);
            end
            MODE_ROTATE: begin
                rx = RW'(vx);
                ry = RW'(vy);
                rz = RW'(vz);
                case (cfg.axis)
                    AXIS_X: begin
                        ry = RW'(p_q15);
                        rz = RW'(q_q15);
                    end
                    AXIS_Y: begin
                        rz = RW'(p_q15);
                        rx = RW'(q_q15);
                    end
                    AXIS_Z: begin
                        rx = RW'(p_q15);
                        ry = RW'(q_q15);
                    end
                    default: begin
                        rx = RW'(vx);
                    end
                endcase
            end
            default: begin
                rx = '0;
                ry = '0;
                rz = '0;
            end
        endcase
    end

    assign cx        = clip(rx);
    assign cy        = clip(ry);
    assign cz        = clip(rz);
    assign ox        = cx[W-1:0];
    assign oy        = cy[W-1:0];
    assign oz        = cz[W-1:0];
    assign saturated = cx[W] | cy[W] | cz[W];

endmodule

`default_nettype wire
